/* hw/rtl/acrc_pkg.sv */
// Shared types, register indexes and constants of the congestion and RTO control block.
package acrc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SEG_SIZE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_RESEND    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RTO        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLUSH_INTERVAL = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SEND_WINDOW    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_CWND    = 3'd5;

  localparam logic [1:0] KIND_RTT   = 2'd0;
  localparam logic [1:0] KIND_ACK   = 2'd1;
  localparam logic [1:0] KIND_FLUSH = 2'd2;

  localparam logic [15:0] SEG_SIZE_RST       = 16'd1376;
  localparam logic [7:0]  FAST_RESEND_RST    = 8'd0;
  localparam logic [15:0] MIN_RTO_RST        = 16'd100;
  localparam logic [12:0] FLUSH_INTERVAL_RST = 13'd100;
  localparam logic [15:0] SEND_WINDOW_RST    = 16'd32;
  localparam logic [15:0] RTO_RST            = 16'd200;
  localparam logic [15:0] RTO_CEIL           = 16'd60000;
  localparam logic [15:0] THRESH_FLOOR       = 16'd2;
  localparam logic [15:0] WIN_MAX            = 16'hffff;
  localparam logic [31:0] CREDIT_MAX         = 32'hffffffff;

  localparam int DIV_CNT_W = 6;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 6'd33;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_RTT_PREP,
    OP_RTT_ACC,
    OP_RTT_UPD,
    OP_RTO_SUM,
    OP_RTO_CLAMP,
    OP_ACK_SLOW,
    OP_ACK_PREP,
    OP_ACK_DIV1,
    OP_ACK_ADD,
    OP_ACK_DIV2,
    OP_ACK_WIN,
    OP_ACK_CAP,
    OP_ACK_CAPW,
    OP_FL_CUT,
    OP_FL_MUL,
    OP_FL_FIN,
    OP_OUT_LOAD
  } op_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       srtt_zero;
    logic       ack_hold;
    logic       ack_slow;
    logic       grow;
    logic       div_done;
    logic       out_free;
  } sts_t;

endpackage

/* hw/rtl/acrc_div.sv */
// Restoring serial divider, one quotient bit per cycle.
module acrc_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] dividend,
  input  logic [31:0] divisor,
  output logic [32:0] quotient,
  output logic        done
);

  logic                             busy_r;
  logic                             done_r;
  logic [acrc_pkg::DIV_CNT_W-1:0]   cnt_r;
  logic [32:0]                      quo_r;
  logic [31:0]                      rem_r;
  logic [31:0]                      dvs_r;
  logic [32:0]                      trial;
  logic [33:0]                      diff;
  logic                             ge;

  assign trial = {rem_r, quo_r[32]};
  assign diff  = {1'b0, trial} - {2'b00, dvs_r};
  assign ge    = ~diff[33];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == {{(acrc_pkg::DIV_CNT_W-1){1'b0}}, 1'b1})) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
      cnt_r <= acrc_pkg::DIV_STEPS;
    end else if (busy_r) begin
      rem_r <= ge ? diff[31:0] : trial[31:0];
      quo_r <= {quo_r[31:0], ge};
      cnt_r <= cnt_r - {{(acrc_pkg::DIV_CNT_W-1){1'b0}}, 1'b1};
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider started while busy");

  a_done_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !start && (cnt_r == {{(acrc_pkg::DIV_CNT_W-1){1'b0}}, 1'b1})) |=> done_r)
    else $error("divider finished without done");

endmodule

/* hw/rtl/acrc_dp.sv */
// Datapath: configuration, window and timer state, multiplier, divider and result register.
module acrc_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  acrc_pkg::op_t                   op,
  output acrc_pkg::sts_t                  sts,
  input  logic                            cfg_we,
  input  logic [acrc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [acrc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [1:0]                      in_kind,
  input  logic [30:0]                     in_rtt_ms,
  input  logic [15:0]                     in_remote_window,
  input  logic [15:0]                     in_in_flight,
  input  logic                            in_fast_resent,
  input  logic                            in_timed_out,
  input  logic                            out_ready,
  output logic                            out_valid,
  output logic [15:0]                     out_rto_ms,
  output logic [15:0]                     out_cong_window,
  output logic [15:0]                     out_slow_start_thresh,
  output logic [31:0]                     out_byte_credit
);

  // configuration
  logic [15:0] seg_r;
  logic [7:0]  frc_r;
  logic [15:0] min_rto_r;
  logic [12:0] flush_int_r;
  logic [15:0] send_win_r;
  logic        ign_r;

  // latched event
  logic [1:0]  kind_r;
  logic [30:0] rtt_r;
  logic [15:0] rwnd_r;
  logic [15:0] infl_r;
  logic        fast_r;
  logic        lost_r;

  // control state
  logic [31:0] srtt_r, srtt_nxt;
  logic [31:0] var_r, var_nxt;
  logic [15:0] rto_r, rto_nxt;
  logic [15:0] cwnd_r, cwnd_nxt;
  logic [31:0] credit_r, credit_nxt;
  logic [15:0] ssth_r, ssth_nxt;

  // scratch
  logic [34:0] acc_a_r, acc_a_nxt;
  logic [34:0] acc_b_r, acc_b_nxt;
  logic [31:0] inc_r, inc_nxt;
  logic [15:0] eff_r, eff_nxt;
  logic        cap_r, cap_nxt;
  logic [32:0] mul_r;

  // result register
  logic        out_valid_r;
  logic [15:0] out_rto_r;
  logic [15:0] out_cwnd_r;
  logic [15:0] out_ssth_r;
  logic [31:0] out_credit_r;

  logic [31:0] rtt_ext;
  logic [31:0] delta;
  logic [34:0] s7;
  logic [34:0] var3_sum;
  logic [31:0] srtt_div8;
  logic [34:0] var4;
  logic [34:0] fi_ext;
  logic [34:0] rto_sum;
  logic [34:0] min_ext;
  logic [34:0] rto_lo;
  logic [15:0] rto_clamped;
  logic [31:0] seg_ext;
  logic [31:0] inc_val;
  logic [32:0] slow_sum;
  logic [31:0] slow_credit;
  logic [32:0] div_quo;
  logic        div_done;
  logic        div_start;
  logic [32:0] div_dividend;
  logic [31:0] div_divisor;
  logic [32:0] q_use;
  logic [33:0] ca_sum;
  logic [31:0] ca_credit;
  logic [32:0] num;
  logic [15:0] seg_nz;
  logic [15:0] win_q;
  logic [15:0] eff0;
  logic [15:0] eff_val;
  logic [15:0] half_inf;
  logic [15:0] th_fast;
  logic [16:0] fsum;
  logic [15:0] fast_win;
  logic [15:0] half_eff;
  logic [15:0] th_lost;
  logic        fast_go;
  logic [16:0] mul_a;
  logic [15:0] mul_b;
  logic [32:0] mul_prod;
  logic        mul_en;

  // RTT smoothing and RTO
  assign rtt_ext     = {1'b0, rtt_r};
  assign delta       = (rtt_ext >= srtt_r) ? (rtt_ext - srtt_r) : (srtt_r - rtt_ext);
  assign s7          = {srtt_r, 3'b000} - {3'b000, srtt_r};
  assign var3_sum    = acc_a_r + {3'b000, var_r};
  assign srtt_div8   = acc_b_r[34:3];
  assign var4        = {1'b0, var_r, 2'b00};
  assign fi_ext      = {22'd0, flush_int_r};
  assign rto_sum     = {3'b000, srtt_r} + ((var4 > fi_ext) ? var4 : fi_ext);
  assign min_ext     = {19'd0, min_rto_r};
  assign rto_lo      = (acc_a_r < min_ext) ? min_ext : acc_a_r;
  assign rto_clamped = (rto_lo > {19'd0, acrc_pkg::RTO_CEIL}) ? acrc_pkg::RTO_CEIL
                                                              : rto_lo[15:0];

  // window growth
  assign seg_ext     = {16'd0, seg_r};
  assign inc_val     = (credit_r < seg_ext) ? seg_ext : credit_r;
  assign slow_sum    = {1'b0, credit_r} + {17'd0, seg_r};
  assign slow_credit = slow_sum[32] ? acrc_pkg::CREDIT_MAX : slow_sum[31:0];
  assign q_use       = (inc_r == '0) ? '0 : div_quo;
  assign ca_sum      = {2'b00, inc_r} + {1'b0, q_use} + {22'd0, seg_r[15:4]};
  assign ca_credit   = (|ca_sum[33:32]) ? acrc_pkg::CREDIT_MAX : ca_sum[31:0];
  assign num         = (slow_sum == '0) ? '0 : (slow_sum - 33'd1);
  assign seg_nz      = (seg_r == '0) ? 16'd1 : seg_r;
  assign win_q       = (|div_quo[32:16]) ? acrc_pkg::WIN_MAX : div_quo[15:0];

  // loss cuts
  assign eff0     = (send_win_r < rwnd_r) ? send_win_r : rwnd_r;
  assign eff_val  = (!ign_r && (cwnd_r < eff0)) ? cwnd_r : eff0;
  assign half_inf = {1'b0, infl_r[15:1]};
  assign th_fast  = (half_inf < acrc_pkg::THRESH_FLOOR) ? acrc_pkg::THRESH_FLOOR : half_inf;
  assign fsum     = {1'b0, th_fast} + {9'd0, frc_r};
  assign fast_win = fsum[16] ? acrc_pkg::WIN_MAX : fsum[15:0];
  assign half_eff = {1'b0, eff_r[15:1]};
  assign th_lost  = (half_eff < acrc_pkg::THRESH_FLOOR) ? acrc_pkg::THRESH_FLOOR : half_eff;
  assign fast_go  = fast_r && (frc_r != '0);

  // shared multiplier
  always_comb begin
    mul_en = 1'b1;
    mul_b  = seg_r;
    unique case (op)
      acrc_pkg::OP_ACK_PREP: mul_a = {1'b0, seg_r};
      acrc_pkg::OP_ACK_ADD:  mul_a = {1'b0, cwnd_r} + 17'd1;
      acrc_pkg::OP_ACK_CAP:  mul_a = {1'b0, rwnd_r};
      acrc_pkg::OP_FL_MUL:   mul_a = {1'b0, cwnd_r};
      default: begin
        mul_a  = {1'b0, cwnd_r};
        mul_en = 1'b0;
      end
    endcase
  end

  assign mul_prod = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      mul_r <= mul_prod;
    end
  end

  // shared divider
  assign div_start    = (op == acrc_pkg::OP_ACK_DIV1) || (op == acrc_pkg::OP_ACK_DIV2);
  assign div_dividend = (op == acrc_pkg::OP_ACK_DIV1) ? mul_r : num;
  assign div_divisor  = (op == acrc_pkg::OP_ACK_DIV1) ? inc_r : {16'd0, seg_nz};

  acrc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .done     (div_done)
  );

  always_comb begin
    srtt_nxt   = srtt_r;
    var_nxt    = var_r;
    rto_nxt    = rto_r;
    cwnd_nxt   = cwnd_r;
    credit_nxt = credit_r;
    ssth_nxt   = ssth_r;
    acc_a_nxt  = acc_a_r;
    acc_b_nxt  = acc_b_r;
    inc_nxt    = inc_r;
    eff_nxt    = eff_r;
    cap_nxt    = cap_r;
    unique case (op)
      acrc_pkg::OP_RTT_PREP: begin
        if (srtt_r == '0) begin
          srtt_nxt = rtt_ext;
          var_nxt  = {1'b0, rtt_ext[31:1]};
        end else begin
          acc_a_nxt = {3'b000, delta};
          acc_b_nxt = s7;
        end
      end
      acrc_pkg::OP_RTT_ACC: begin
        acc_a_nxt = acc_a_r + {2'b00, var_r, 1'b0};
        acc_b_nxt = acc_b_r + {4'd0, rtt_r};
      end
      acrc_pkg::OP_RTT_UPD: begin
        var_nxt  = var3_sum[33:2];
        srtt_nxt = (srtt_div8 == '0) ? 32'd1 : srtt_div8;
      end
      acrc_pkg::OP_RTO_SUM:   acc_a_nxt = rto_sum;
      acrc_pkg::OP_RTO_CLAMP: rto_nxt = rto_clamped;
      acrc_pkg::OP_ACK_SLOW: begin
        cwnd_nxt   = cwnd_r + 16'd1;
        credit_nxt = slow_credit;
      end
      acrc_pkg::OP_ACK_PREP: inc_nxt = inc_val;
      acrc_pkg::OP_ACK_ADD:  credit_nxt = ca_credit;
      acrc_pkg::OP_ACK_WIN:  cwnd_nxt = win_q;
      acrc_pkg::OP_ACK_CAP: begin
        cap_nxt = cwnd_r > rwnd_r;
        if (cwnd_r > rwnd_r) begin
          cwnd_nxt = rwnd_r;
        end
      end
      acrc_pkg::OP_ACK_CAPW: begin
        if (cap_r) begin
          credit_nxt = mul_r[31:0];
        end
      end
      acrc_pkg::OP_FL_CUT: begin
        eff_nxt = eff_val;
        if (fast_go) begin
          ssth_nxt = th_fast;
          cwnd_nxt = fast_win;
        end
      end
      acrc_pkg::OP_FL_FIN: begin
        if (fast_go) begin
          credit_nxt = mul_r[31:0];
        end
        if (lost_r) begin
          ssth_nxt = th_lost;
        end
        if (lost_r || (cwnd_r == '0)) begin
          cwnd_nxt   = 16'd1;
          credit_nxt = seg_ext;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r       <= acrc_pkg::SEG_SIZE_RST;
      frc_r       <= acrc_pkg::FAST_RESEND_RST;
      min_rto_r   <= acrc_pkg::MIN_RTO_RST;
      flush_int_r <= acrc_pkg::FLUSH_INTERVAL_RST;
      send_win_r  <= acrc_pkg::SEND_WINDOW_RST;
      ign_r       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        acrc_pkg::CFG_SEG_SIZE:       seg_r       <= cfg_wdata;
        acrc_pkg::CFG_FAST_RESEND:    frc_r       <= cfg_wdata[7:0];
        acrc_pkg::CFG_MIN_RTO:        min_rto_r   <= cfg_wdata;
        acrc_pkg::CFG_FLUSH_INTERVAL: flush_int_r <= cfg_wdata[12:0];
        acrc_pkg::CFG_SEND_WINDOW:    send_win_r  <= cfg_wdata;
        acrc_pkg::CFG_IGNORE_CWND:    ign_r       <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      srtt_r   <= '0;
      var_r    <= '0;
      rto_r    <= acrc_pkg::RTO_RST;
      cwnd_r   <= '0;
      credit_r <= '0;
      ssth_r   <= acrc_pkg::THRESH_FLOOR;
    end else begin
      srtt_r   <= srtt_nxt;
      var_r    <= var_nxt;
      rto_r    <= rto_nxt;
      cwnd_r   <= cwnd_nxt;
      credit_r <= credit_nxt;
      ssth_r   <= ssth_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_a_r <= acc_a_nxt;
    acc_b_r <= acc_b_nxt;
    inc_r   <= inc_nxt;
    eff_r   <= eff_nxt;
    cap_r   <= cap_nxt;
    if (op == acrc_pkg::OP_LOAD) begin
      kind_r <= in_kind;
      rtt_r  <= in_rtt_ms;
      rwnd_r <= in_remote_window;
      infl_r <= in_in_flight;
      fast_r <= in_fast_resent;
      lost_r <= in_timed_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (op == acrc_pkg::OP_OUT_LOAD) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op == acrc_pkg::OP_OUT_LOAD) begin
      out_rto_r    <= rto_r;
      out_cwnd_r   <= cwnd_r;
      out_ssth_r   <= ssth_r;
      out_credit_r <= credit_r;
    end
  end

  assign sts.kind      = kind_r;
  assign sts.srtt_zero = (srtt_r == '0);
  assign sts.ack_hold  = (cwnd_r >= rwnd_r);
  assign sts.ack_slow  = (cwnd_r < ssth_r);
  assign sts.grow      = (mul_r <= {1'b0, credit_r});
  assign sts.div_done  = div_done;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid             = out_valid_r;
  assign out_rto_ms            = out_rto_r;
  assign out_cong_window       = out_cwnd_r;
  assign out_slow_start_thresh = out_ssth_r;
  assign out_byte_credit       = out_credit_r;

  a_flush_min_window: assert property (@(posedge clk) disable iff (!rst_n)
    (op == acrc_pkg::OP_FL_FIN) |=> (cwnd_r != '0))
    else $error("window empty after flush report");

  a_rto_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
    (op == acrc_pkg::OP_RTO_CLAMP) |=> (rto_r <= acrc_pkg::RTO_CEIL))
    else $error("timeout above ceiling");

  a_thresh_floor: assert property (@(posedge clk) disable iff (!rst_n)
    ssth_r >= acrc_pkg::THRESH_FLOOR)
    else $error("slow start threshold below floor");

endmodule

/* hw/rtl/acrc_ctl.sv */
// Controller: sequences the datapath steps for each event kind.
module acrc_ctl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  acrc_pkg::sts_t sts,
  output acrc_pkg::op_t  op
);

  typedef enum logic [17:0] {
    S_IDLE      = 18'h00001,
    S_DISP      = 18'h00002,
    S_RTT_PREP  = 18'h00004,
    S_RTT_ACC   = 18'h00008,
    S_RTT_UPD   = 18'h00010,
    S_RTO_SUM   = 18'h00020,
    S_RTO_CLAMP = 18'h00040,
    S_ACK_CHK   = 18'h00080,
    S_ACK_DIV1  = 18'h00100,
    S_ACK_WAIT1 = 18'h00200,
    S_ACK_CMP   = 18'h00400,
    S_ACK_WAIT2 = 18'h00800,
    S_ACK_CAP   = 18'h01000,
    S_ACK_CAPW  = 18'h02000,
    S_FL_CUT    = 18'h04000,
    S_FL_MUL    = 18'h08000,
    S_FL_FIN    = 18'h10000,
    S_DONE      = 18'h20000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    op        = acrc_pkg::OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          op        = acrc_pkg::OP_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        unique case (sts.kind)
          acrc_pkg::KIND_RTT:   state_nxt = S_RTT_PREP;
          acrc_pkg::KIND_ACK:   state_nxt = S_ACK_CHK;
          acrc_pkg::KIND_FLUSH: state_nxt = S_FL_CUT;
          default:              state_nxt = S_DONE;
        endcase
      end
      S_RTT_PREP: begin
        op        = acrc_pkg::OP_RTT_PREP;
        state_nxt = sts.srtt_zero ? S_RTO_SUM : S_RTT_ACC;
      end
      S_RTT_ACC: begin
        op        = acrc_pkg::OP_RTT_ACC;
        state_nxt = S_RTT_UPD;
      end
      S_RTT_UPD: begin
        op        = acrc_pkg::OP_RTT_UPD;
        state_nxt = S_RTO_SUM;
      end
      S_RTO_SUM: begin
        op        = acrc_pkg::OP_RTO_SUM;
        state_nxt = S_RTO_CLAMP;
      end
      S_RTO_CLAMP: begin
        op        = acrc_pkg::OP_RTO_CLAMP;
        state_nxt = S_DONE;
      end
      S_ACK_CHK: begin
        priority if (sts.ack_hold) begin
          state_nxt = S_DONE;
        end else if (sts.ack_slow) begin
          op        = acrc_pkg::OP_ACK_SLOW;
          state_nxt = S_ACK_CAP;
        end else begin
          op        = acrc_pkg::OP_ACK_PREP;
          state_nxt = S_ACK_DIV1;
        end
      end
      S_ACK_DIV1: begin
        op        = acrc_pkg::OP_ACK_DIV1;
        state_nxt = S_ACK_WAIT1;
      end
      S_ACK_WAIT1: begin
        if (sts.div_done) begin
          op        = acrc_pkg::OP_ACK_ADD;
          state_nxt = S_ACK_CMP;
        end
      end
      S_ACK_CMP: begin
        if (sts.grow) begin
          op        = acrc_pkg::OP_ACK_DIV2;
          state_nxt = S_ACK_WAIT2;
        end else begin
          state_nxt = S_ACK_CAP;
        end
      end
      S_ACK_WAIT2: begin
        if (sts.div_done) begin
          op        = acrc_pkg::OP_ACK_WIN;
          state_nxt = S_ACK_CAP;
        end
      end
      S_ACK_CAP: begin
        op        = acrc_pkg::OP_ACK_CAP;
        state_nxt = S_ACK_CAPW;
      end
      S_ACK_CAPW: begin
        op        = acrc_pkg::OP_ACK_CAPW;
        state_nxt = S_DONE;
      end
      S_FL_CUT: begin
        op        = acrc_pkg::OP_FL_CUT;
        state_nxt = S_FL_MUL;
      end
      S_FL_MUL: begin
        op        = acrc_pkg::OP_FL_MUL;
        state_nxt = S_FL_FIN;
      end
      S_FL_FIN: begin
        op        = acrc_pkg::OP_FL_FIN;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          op        = acrc_pkg::OP_OUT_LOAD;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* hw/rtl/arq_congestion_and_rto_control.sv */
// Top level of the sender-side congestion window and retransmit timeout control.
//
// Usage:
//   cfg_we/cfg_idx/cfg_wdata write one setting (segment size, fast
//   resend threshold, minimum RTO, flush interval, send window, ignore-cwnd);
//   write only while no event is in progress.
//   The in_ channel carries one event per transfer: RTT sample, ack advance or
//   flush report. Every event gives exactly one transfer on the out_ channel,
//   a snapshot of RTO, congestion window, slow start threshold and byte credit.
//   Events are handled one at a time. Congestion avoidance runs the shared
//   33-step serial divider once, and a second time when it also grows the
//   window; slow start growth, flush reports and RTT samples take no divide,
//   and a held window or an unused kind goes straight to the result. in_ready
//   returns the cycle after the result enters the output register.
//   A result waiting on a stalled receiver does not block the next event from
//   being accepted; that event holds in its final step until the output
//   register frees. Reset (rst_n low, synchronous) restores the setting
//   defaults, RTO 200, window 0, threshold 2, credit 0 and no RTT sample.
module arq_congestion_and_rto_control (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [acrc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [acrc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      in_kind,
  input  logic [30:0]                     in_rtt_ms,
  input  logic [15:0]                     in_remote_window,
  input  logic [15:0]                     in_in_flight,
  input  logic                            in_fast_resent,
  input  logic                            in_timed_out,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [15:0]                     out_rto_ms,
  output logic [15:0]                     out_cong_window,
  output logic [15:0]                     out_slow_start_thresh,
  output logic [31:0]                     out_byte_credit
);

  acrc_pkg::op_t  op;
  acrc_pkg::sts_t sts;

  acrc_ctl u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .op       (op)
  );

  acrc_dp u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .op                    (op),
    .sts                   (sts),
    .cfg_we                (cfg_we),
    .cfg_idx               (cfg_idx),
    .cfg_wdata             (cfg_wdata),
    .in_kind               (in_kind),
    .in_rtt_ms             (in_rtt_ms),
    .in_remote_window      (in_remote_window),
    .in_in_flight          (in_in_flight),
    .in_fast_resent        (in_fast_resent),
    .in_timed_out          (in_timed_out),
    .out_ready             (out_ready),
    .out_valid             (out_valid),
    .out_rto_ms            (out_rto_ms),
    .out_cong_window       (out_cong_window),
    .out_slow_start_thresh (out_slow_start_thresh),
    .out_byte_credit       (out_byte_credit)
  );

endmodule
